### design/lpsa_pkg.sv
package lpsa_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_ADJUST_DISABLE    = 3'd0;
    localparam logic [2:0] CFG_NOMINAL_SPEED     = 3'd1;
    localparam logic [2:0] CFG_DATA_CRC_ENABLE   = 3'd2;
    localparam logic [2:0] CFG_WRITE_AHEAD_SECS  = 3'd3;
    localparam logic [2:0] CFG_INITIAL_DATA_SIZE = 3'd4;

    // Field widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int RATE_W      = 24;
    localparam int SECS_W      = 8;
    localparam int INIT_SIZE_W = 11;
    localparam int COUNT_W     = 32;
    localparam int ITER_W      = 5;

    // Size change codes
    typedef logic [1:0] t_change;
    localparam t_change CHG_NONE   = 2'd0;
    localparam t_change CHG_HALVED = 2'd1;
    localparam t_change CHG_DOUBLED = 2'd2;

endpackage

### design/link_packet_size_adapter_core.sv
// Link packet size adapter. Each rate_report word (remote throughput in bytes/s)
// yields exactly one result word carrying the data size in force, the held
// write-ahead packet count and the kind of size change. A report that leaves
// the size unchanged passes through accept, decide and output. A report that
// halves or doubles the size passes through accept, decide, set up of the count
// dividend, 32 steps of a one-bit-per-cycle restoring divider, and output.
// Input stall stays high from acceptance until the result is loaded into the
// output register, so the next report is taken while a finished result still
// waits downstream.
// Configuration writes are taken at any time but must only be issued while
// the block is idle; writing initial_data_size clamps it and loads it at once.
module link_packet_size_adapter_core #(
    parameter int MIN_DATA_SIZE = 64,
    parameter int MAX_DATA_SIZE = 1024,
    parameter int HEADER_BYTES  = 6,
    parameter int CRC_BYTES     = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lpsa_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lpsa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // report input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lpsa_pkg::RATE_W-1:0]         i_rate_report,
    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lpsa_pkg::INIT_SIZE_W-1:0]    o_data_size,
    output logic [lpsa_pkg::COUNT_W-1:0]        o_inflight_count,
    output logic [1:0]                          o_size_change
);

    localparam int SIZE_W = lpsa_pkg::INIT_SIZE_W;
    localparam int PKT_W = $clog2(MAX_DATA_SIZE + HEADER_BYTES + 2 * CRC_BYTES + 1);
    localparam int REM_W = PKT_W + 1;
    localparam int RW    = lpsa_pkg::RATE_W;
    localparam int CW    = lpsa_pkg::COUNT_W;
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(MIN_DATA_SIZE);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_DATA_SIZE);
    localparam logic [SIZE_W-1:0] SIZE_RST =
        SIZE_W'((1024 < MIN_DATA_SIZE) ? MIN_DATA_SIZE :
                (1024 > MAX_DATA_SIZE) ? MAX_DATA_SIZE : 1024);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    // configuration registers
    logic                               r_adjust_disable;
    logic [RW-1:0]                      r_nominal_speed;
    logic                               r_crc_enable;
    logic [lpsa_pkg::SECS_W-1:0]        r_write_ahead_secs;

    // adapter state
    logic [SIZE_W-1:0]                  r_size,      n_size;
    logic [RW-1:0]                      r_prev_rate, n_prev_rate;
    logic [RW-1:0]                      r_last_rate, n_last_rate;
    logic [CW-1:0]                      r_held,      n_held;

    // sequencer and divider
    logic [2:0]                         r_state,  n_state;
    logic [RW-1:0]                      r_rate,   n_rate;
    logic [1:0]                         r_change, n_change;
    logic [REM_W-1:0]                   r_rem,    n_rem;
    logic [CW-1:0]                      r_quo,    n_quo;
    logic [PKT_W-1:0]                   r_div,    n_div;
    logic [lpsa_pkg::ITER_W-1:0]        r_iter,   n_iter;

    // output register
    logic                               r_out_valid, n_out_valid;
    logic [SIZE_W-1:0]                  r_out_size,  n_out_size;
    logic [CW-1:0]                      r_out_count, n_out_count;
    logic [1:0]                         r_out_change, n_out_change;

    logic                               w_cfg_we;
    logic                               w_in_take;
    logic                               w_out_free;
    logic                               w_enabled;
    logic [RW+1:0]                      w_low_mark;
    logic [RW+2:0]                      w_high_sum;
    logic [RW+1:0]                      w_high_mark;
    logic [PKT_W-1:0]                   w_pkt;
    logic [SIZE_W+2:0]                  w_size_x5;
    logic [SIZE_W-1:0]                  w_half;
    logic [SIZE_W:0]                    w_twice;
    logic                               w_do_halve;
    logic                               w_do_double;
    logic [CW-1:0]                      w_dividend;
    logic [REM_W-1:0]                   w_rem_shift;
    logic                               w_fits;
    logic [lpsa_pkg::INIT_SIZE_W-1:0]   w_init;
    logic [SIZE_W-1:0]                  w_init_clamped;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;
    assign o_stall     = (r_state != ST_IDLE);
    assign w_in_take   = i_valid & ~o_stall;
    assign w_out_free  = ~r_out_valid | ~i_stall;

    assign o_valid          = r_out_valid;
    assign o_data_size      = r_out_size;
    assign o_inflight_count = r_out_count;
    assign o_size_change    = r_out_change;

    // clamp written initial size into the legal range
    assign w_init = i_cfg_data[lpsa_pkg::INIT_SIZE_W-1:0];
    always_comb begin
        if (32'(w_init) < 32'(MIN_DATA_SIZE)) begin
            w_init_clamped = SIZE_MIN;
        end else if (32'(w_init) > 32'(MAX_DATA_SIZE)) begin
            w_init_clamped = SIZE_MAX;
        end else begin
            w_init_clamped = SIZE_W'(w_init);
        end
    end

    // thresholds at 3/4 and 7/8 of nominal speed; 7x speed needs 27 bits
    assign w_enabled   = ~r_adjust_disable & (r_nominal_speed != '0);
    assign w_low_mark  = ({2'b00, r_nominal_speed} + {1'b0, r_nominal_speed, 1'b0}) >> 2;
    assign w_high_sum  = {1'b0, r_nominal_speed, 2'b00} + {3'b000, r_nominal_speed}
                       + {2'b00, r_nominal_speed, 1'b0};
    assign w_high_mark = {2'b00, w_high_sum[RW+2:3]};

    // full packet bytes for the size currently held
    assign w_pkt = PKT_W'(r_size) + PKT_W'(HEADER_BYTES + CRC_BYTES)
                 + (r_crc_enable ? PKT_W'(CRC_BYTES) : PKT_W'(0));

    assign w_size_x5 = {r_size, 2'b00} + (SIZE_W + 3)'(r_size);
    assign w_half    = r_size >> 1;
    assign w_twice   = {r_size, 1'b0};

    // halve / double decisions
    always_comb begin
        w_do_halve  = 1'b0;
        w_do_double = 1'b0;
        if ((RW + 2)'(r_rate) < w_low_mark) begin
            w_do_halve = ~((r_rate > r_prev_rate) && (r_prev_rate != '0))
                       && ((r_rate < r_last_rate) || (r_last_rate == '0))
                       && (r_size > SIZE_MIN)
                       && (32'(r_rate) < 32'(w_size_x5));
        end else if ((RW + 2)'(r_rate) > w_high_mark) begin
            w_do_double = ~(r_rate < r_prev_rate)
                        && (r_rate > r_last_rate)
                        && (r_size < SIZE_MAX)
                        && (32'(w_pkt) < 32'(r_nominal_speed));
        end
    end

    // count dividend: seconds * speed + packet - 1, fits in 32 bits
    assign w_dividend = CW'(r_write_ahead_secs) * CW'(r_nominal_speed)
                      + CW'(w_pkt) - CW'(1);

    // one restoring division step
    assign w_rem_shift = {r_rem[REM_W-2:0], r_quo[CW-1]};
    assign w_fits      = (w_rem_shift >= REM_W'(r_div));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adjust_disable   <= 1'b0;
            r_nominal_speed    <= '0;
            r_crc_enable       <= 1'b1;
            r_write_ahead_secs <= lpsa_pkg::SECS_W'(1);
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                lpsa_pkg::CFG_ADJUST_DISABLE:   r_adjust_disable   <= i_cfg_data[0];
                lpsa_pkg::CFG_NOMINAL_SPEED:    r_nominal_speed    <= i_cfg_data[RW-1:0];
                lpsa_pkg::CFG_DATA_CRC_ENABLE:  r_crc_enable       <= i_cfg_data[0];
                lpsa_pkg::CFG_WRITE_AHEAD_SECS: begin
                    r_write_ahead_secs <= i_cfg_data[lpsa_pkg::SECS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_size       = r_size;
        n_prev_rate  = r_prev_rate;
        n_last_rate  = r_last_rate;
        n_held       = r_held;
        n_rate       = r_rate;
        n_change     = r_change;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_div        = r_div;
        n_iter       = r_iter;
        n_out_valid  = r_out_valid & i_stall;
        n_out_size   = r_out_size;
        n_out_count  = r_out_count;
        n_out_change = r_out_change;

        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_rate  = i_rate_report;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_change = lpsa_pkg::CHG_NONE;
                n_state  = ST_OUT;
                if (w_enabled) begin
                    n_prev_rate = r_rate;
                    if (w_do_halve) begin
                        n_size      = (w_half < SIZE_MIN) ? SIZE_MIN : w_half;
                        n_change    = lpsa_pkg::CHG_HALVED;
                        n_last_rate = r_rate;
                        n_state     = ST_SETUP;
                    end else if (w_do_double) begin
                        n_size      = (w_twice > (SIZE_W + 1)'(MAX_DATA_SIZE))
                                    ? SIZE_MAX : w_twice[SIZE_W-1:0];
                        n_change    = lpsa_pkg::CHG_DOUBLED;
                        n_last_rate = r_rate;
                        n_state     = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                n_rem   = '0;
                n_quo   = w_dividend;
                n_div   = w_pkt;
                n_iter  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem  = w_fits ? (w_rem_shift - REM_W'(r_div)) : w_rem_shift;
                n_quo  = {r_quo[CW-2:0], w_fits};
                n_iter = r_iter + 1'b1;
                if (r_iter == lpsa_pkg::ITER_W'(CW - 1)) begin
                    n_held  = {r_quo[CW-2:0], w_fits};
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_size   = r_size;
                    n_out_count  = r_held;
                    n_out_change = r_change;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // initial size write loads the size at once
        if (w_cfg_we && (i_cfg_index == lpsa_pkg::CFG_INITIAL_DATA_SIZE)) begin
            n_size = w_init_clamped;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= SIZE_RST;
            r_prev_rate <= '0;
            r_last_rate <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_prev_rate <= n_prev_rate;
            r_last_rate <= n_last_rate;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            r_iter      <= n_iter;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rate       <= n_rate;
        r_change     <= n_change;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_div        <= n_div;
        r_out_size   <= n_out_size;
        r_out_count  <= n_out_count;
        r_out_change <= n_out_change;
    end

`ifndef SYNTHESIS
    // an accepted report is decided on the next cycle
    a_take_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == ST_DECIDE))
        else $error("accepted report did not reach decision");

    // divider remainder stays below the packet size
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < REM_W'(r_div)))
        else $error("divider remainder out of range");

    // delivered size stays within limits
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data_size >= SIZE_MIN) && (o_data_size <= SIZE_MAX)))
        else $error("data size outside limits");

    // an unchanged size leaves the count untouched
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DECIDE) && (n_state == ST_OUT)) |=> $stable(r_held))
        else $error("held count changed without a size change");
`endif

endmodule

### tb/size_adapter_checker.sv
module size_adapter_checker
    import lpsa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    input  logic                   i_in_stall,
    input  logic [RATE_W-1:0]      i_rate_report,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [10:0]            i_data_size,
    input  logic [COUNT_W-1:0]     i_inflight_count,
    input  logic [1:0]             i_size_change,
    output int                     o_mismatches,
    output int                     o_outstanding,
    output int                     o_halvings,
    output int                     o_doublings
);

    localparam int MIN_SIZE = 64;
    localparam int MAX_SIZE = 1024;
    localparam int HDR      = 6;
    localparam int CRC      = 2;

    typedef struct packed {
        logic [10:0]        size_now;
        logic [COUNT_W-1:0] inflight;
        t_change            change;
    } t_size_decision;

    t_size_decision size_decisions[$];

    // register copies
    logic               adjust_off;
    logic [RATE_W-1:0]  link_speed;
    logic               crc_on;
    logic [SECS_W-1:0]  ahead_secs;

    // adapter state
    logic [10:0]        cur_size;
    logic [RATE_W-1:0]  last_rate;
    logic [RATE_W-1:0]  change_rate;
    logic [COUNT_W-1:0] held_count;

    int mismatches = 0;
    int halvings   = 0;
    int doublings  = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = size_decisions.size();
    assign o_halvings    = halvings;
    assign o_doublings   = doublings;

    function automatic logic [10:0] limit_size(input logic [10:0] s);
        if (s < MIN_SIZE) return 11'(MIN_SIZE);
        if (s > MAX_SIZE) return 11'(MAX_SIZE);
        return s;
    endfunction

    // data plus header, header CRC and optional data CRC
    function automatic logic [12:0] wire_bytes(input logic [10:0] s);
        return 13'(s) + 13'(HDR + CRC) + (crc_on ? 13'(CRC) : 13'd0);
    endfunction

    // Decide halve/double/hold for one report and queue the word it should produce
    task automatic adapt_packet_size(input logic [RATE_W-1:0] rate);
        logic [27:0] low_mark;
        logic [27:0] high_mark;
        logic [11:0] next_size;
        logic [12:0] pkt;
        logic [39:0] dividend;
        t_change     change;
        begin
            change = CHG_NONE;
            if (!adjust_off && link_speed != 0) begin
                low_mark  = (28'(link_speed) * 28'd3) / 28'd4;
                high_mark = (28'(link_speed) * 28'd7) / 28'd8;
                if (28'(rate) < low_mark) begin
                    // halve only when not recovering and below the last change point
                    if (!(rate > last_rate && last_rate != 0) &&
                        (rate < change_rate || change_rate == 0) &&
                        cur_size > MIN_SIZE && 24'(cur_size) > rate / 24'd5) begin
                        next_size = 12'(cur_size >> 1);
                        cur_size  = (next_size < MIN_SIZE) ? 11'(MIN_SIZE) : next_size[10:0];
                        change    = CHG_HALVED;
                    end
                end else if (28'(rate) > high_mark) begin
                    // double only when not falling and the packet fits the link
                    if (rate >= last_rate && rate > change_rate && cur_size < MAX_SIZE &&
                        24'(wire_bytes(cur_size)) < link_speed) begin
                        next_size = {cur_size, 1'b0};
                        cur_size  = (next_size > MAX_SIZE) ? 11'(MAX_SIZE) : next_size[10:0];
                        change    = CHG_DOUBLED;
                    end
                end
                // recompute the write-ahead count as a ceiling division
                if (change != CHG_NONE) begin
                    pkt         = wire_bytes(cur_size);
                    dividend    = 40'(ahead_secs) * 40'(link_speed) + 40'(pkt) - 40'd1;
                    held_count  = 32'(dividend / 40'(pkt));
                    change_rate = rate;
                    if (change == CHG_HALVED) halvings++;
                    else doublings++;
                end
                last_rate = rate;
            end
            size_decisions.push_back('{cur_size, held_count, change});
        end
    endtask

    always @(posedge i_clk) begin
        t_size_decision want;
        if (!i_rst_n) begin
            adjust_off  = 1'b0;
            link_speed  = '0;
            crc_on      = 1'b1;
            ahead_secs  = 8'd1;
            cur_size    = 11'(MAX_SIZE);
            last_rate   = '0;
            change_rate = '0;
            held_count  = '0;
            size_decisions.delete();
        end else begin
            // track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ADJUST_DISABLE:    adjust_off = i_cfg_data[0];
                    CFG_NOMINAL_SPEED:     link_speed = i_cfg_data;
                    CFG_DATA_CRC_ENABLE:   crc_on     = i_cfg_data[0];
                    CFG_WRITE_AHEAD_SECS:  ahead_secs = i_cfg_data[SECS_W-1:0];
                    CFG_INITIAL_DATA_SIZE: cur_size   = limit_size(i_cfg_data[10:0]);
                    default: ;
                endcase
            end
            // compare an accepted result word against the oldest decision
            if (i_out_valid && !i_out_stall) begin
                if (size_decisions.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected: data_size %0d count %0d change %0d",
                             $time, i_data_size, i_inflight_count, i_size_change);
                end else begin
                    want = size_decisions.pop_front();
                    if (i_data_size !== want.size_now) begin
                        mismatches++;
                        $display("%0t: data_size expected %0d, got %0d",
                                 $time, want.size_now, i_data_size);
                    end
                    if (i_inflight_count !== want.inflight) begin
                        mismatches++;
                        $display("%0t: inflight_count expected %0d, got %0d",
                                 $time, want.inflight, i_inflight_count);
                    end
                    if (i_size_change !== want.change) begin
                        mismatches++;
                        $display("%0t: size_change expected %0d, got %0d",
                                 $time, want.change, i_size_change);
                    end
                end
            end
            // predict for an accepted report word
            if (i_valid && !i_in_stall) adapt_packet_size(i_rate_report);
        end
    end

endmodule

### tb/testbench.sv
module testbench;
    import lpsa_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int END_CYCLES   = 80;
    localparam int NUM_PHASES   = 12;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic [RATE_W-1:0]      i_rate_report;
    logic                   o_valid;
    logic                   i_stall;
    logic [10:0]            o_data_size;
    logic [COUNT_W-1:0]     o_inflight_count;
    logic [1:0]             o_size_change;

    int  mismatches;
    int  outstanding;
    int  halvings;
    int  doublings;
    int  reports_sent = 0;
    int  burst_left   = 0;
    int  long_holds   = 0;
    int  cycle_count  = 0;
    bit  idle_free    = 1'b0;
    bit  long_hold_req = 1'b0;

    link_packet_size_adapter_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rate_report    (i_rate_report),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_data_size      (o_data_size),
        .o_inflight_count (o_inflight_count),
        .o_size_change    (o_size_change)
    );

    size_adapter_checker adapter_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .i_in_stall       (o_stall),
        .i_rate_report    (i_rate_report),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_data_size      (o_data_size),
        .i_inflight_count (o_inflight_count),
        .i_size_change    (o_size_change),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding),
        .o_halvings       (halvings),
        .o_doublings      (doublings)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up after a generous number of cycles
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk) cycle_count++;
        $display("%0d results still outstanding at timeout", outstanding);
        $display("link_packet_size_adapter_core regression: fail");
        $finish;
    end

    // Output stall: segments of random style, plus a long hold-off on request
    initial begin
        int seg_left = 0;
        int style    = 0;
        int run;
        i_stall = 1'b0;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                long_holds++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    style    = $urandom_range(0, 3);
                    seg_left = $urandom_range(50, 300);
                end
                run = (style == 3) ? $urandom_range(1, 12) : 1;
                case (style)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 7) == 0);
                    2: i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= $urandom_range(0, 1);
                endcase
                seg_left = (seg_left > run) ? seg_left - run : 0;
                repeat (run) @(negedge i_clk);
            end
        end
    end

    function automatic logic [RATE_W-1:0] fit_rate(input longint v);
        if (v < 0) return '0;
        if (v > 24'hFFFFFF) return 24'hFFFFFF;
        return v[RATE_W-1:0];
    endfunction

    // Offer one report word in bursts with random gaps; returns at a falling edge
    task automatic send_rate(input logic [RATE_W-1:0] rate);
        int gap;
        begin
            if (burst_left == 0) begin
                burst_left = idle_free ? 1000 : $urandom_range(1, 12);
                gap        = idle_free ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
            i_valid       <= 1'b1;
            i_rate_report <= rate;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            reports_sent++;
            @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every result word has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    // Write one register; bits above the field width get random filler
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] v,
                             input int w);
        logic [23:0] keep;
        begin
            keep = (w >= 24) ? 24'hFFFFFF : ((24'd1 << w) - 24'd1);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= (24'($urandom) & ~keep) | (v & keep);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    // Walk through zero speed, disable, halving down to the floor, doubling up
    // to the ceiling, clamped initial sizes, odd sizes, and an unknown index
    task automatic run_directed();
        logic [RATE_W-1:0] seq[$];
        begin
            send_rate(24'd0);
            send_rate(24'hFFFFFF);

            drain_results();
            write_reg(CFG_NOMINAL_SPEED, 24'd4000, 24);
            write_reg(CFG_ADJUST_DISABLE, 24'd1, 1);
            i_cfg_valid <= 1'b0;
            send_rate(24'd100);

            drain_results();
            write_reg(CFG_ADJUST_DISABLE, 24'd0, 1);
            i_cfg_valid <= 1'b0;
            seq = '{24'd1000, 24'd900, 24'd800, 24'd700, 24'd100, 24'd50, 24'd60,
                    24'd3600, 24'd3700, 24'd3600, 24'd3700, 24'd3800, 24'd3900,
                    24'd4000, 24'd3200};
            foreach (seq[k]) send_rate(seq[k]);

            // odd size doubles past the ceiling and saturates
            drain_results();
            write_reg(CFG_INITIAL_DATA_SIZE, 24'd1000, 11);
            i_cfg_valid <= 1'b0;
            send_rate(24'hFFFFFF);

            // odd size halves past the floor and saturates
            drain_results();
            write_reg(CFG_INITIAL_DATA_SIZE, 24'd100, 11);
            write_reg(CFG_DATA_CRC_ENABLE, 24'd0, 1);
            write_reg(CFG_WRITE_AHEAD_SECS, 24'd255, 8);
            i_cfg_valid <= 1'b0;
            send_rate(24'd10);

            drain_results();
            write_reg(CFG_INITIAL_DATA_SIZE, 24'd0, 11);
            write_reg(3'd5, 24'hA5A5A5, 0);
            i_cfg_valid <= 1'b0;
            send_rate(24'd3000);

            drain_results();
            write_reg(CFG_INITIAL_DATA_SIZE, 24'd2047, 11);
            write_reg(CFG_WRITE_AHEAD_SECS, 24'd0, 8);
            i_cfg_valid <= 1'b0;
            send_rate(24'd5);
        end
    endtask

    // One configuration phase followed by ramps, noise and threshold probes
    task automatic run_phase(input int ph);
        logic [23:0] speed;
        logic        off;
        longint      low;
        longint      high;
        longint      r;
        int          items;
        int          n;
        int          kind;
        int          len;
        bit          paused;
        begin
            off = 1'b0;
            case (ph)
                0: speed = 24'd4000;
                1: speed = 24'd1200;
                2: speed = 24'hFFFFFF;
                3: speed = 24'd1;
                4: begin speed = 24'd3000; off = 1'b1; end
                5: speed = 24'd0;
                default: begin
                    speed = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(500, 60000));
                    off   = ($urandom_range(0, 7) == 0);
                end
            endcase

            drain_results();
            write_reg(CFG_ADJUST_DISABLE, 24'(off), 1);
            write_reg(CFG_NOMINAL_SPEED, speed, 24);
            write_reg(CFG_DATA_CRC_ENABLE, (ph == 1) ? 24'd0 : 24'($urandom_range(0, 1)), 1);
            write_reg(CFG_WRITE_AHEAD_SECS,
                      (ph == 1 || ph == 2) ? 24'd255 :
                      (ph == 3) ? 24'd0 : 24'($urandom_range(0, 255)), 8);
            write_reg(CFG_INITIAL_DATA_SIZE,
                      (ph == 0) ? 24'd1024 : (ph == 1) ? 24'd1000 :
                      (ph == 2) ? 24'd64 : 24'($urandom_range(0, 2047)), 11);
            write_reg(CFG_INDEX_W'($urandom_range(5, 7)), 24'($urandom), 0);
            i_cfg_valid <= 1'b0;

            idle_free = (ph == 2) || ($urandom_range(0, 3) == 0);
            burst_left = 0;
            if (ph == 2) long_hold_req = 1'b1;

            low    = (longint'(speed) * 3) / 4;
            high   = (longint'(speed) * 7) / 8;
            items  = (ph >= 3 && ph <= 5) ? 40 : 95;
            n      = 0;
            paused = 1'b0;
            while (n < items) begin
                kind = $urandom_range(0, 9);
                len  = $urandom_range(2, 8);
                if (kind <= 3) begin
                    // falling ramp below the low mark: successive halvings
                    r = $urandom_range(0, 1) ? $urandom_range(0, int'(low))
                                             : $urandom_range(0, (low < 5200) ? int'(low) : 5200);
                    repeat (len) begin
                        send_rate(fit_rate(r));
                        n++;
                        r = r - $urandom_range(1, int'(r / 3) + 1);
                    end
                end else if (kind <= 6) begin
                    // rising ramp above the high mark: successive doublings
                    r = high + 1 + $urandom_range(0, int'(speed / 8));
                    repeat (len) begin
                        send_rate(fit_rate(r));
                        n++;
                        r = r + $urandom_range(0, int'(speed / 16) + 1);
                    end
                end else if (kind == 7) begin
                    send_rate(24'($urandom));
                    n++;
                end else if (kind == 8) begin
                    case ($urandom_range(0, 5))
                        0: r = low - 1;
                        1: r = low;
                        2: r = high;
                        3: r = high + 1;
                        4: r = 0;
                        default: r = 24'hFFFFFF;
                    endcase
                    send_rate(fit_rate(r));
                    n++;
                end else begin
                    send_rate(fit_rate($urandom_range(int'(low), int'(high))));
                    n++;
                end
                // in phases 0 and 7, hold the sender once at the halfway point until all results are back
                if ((ph == 0 || ph == 7) && !paused && n >= items / 2) begin
                    paused = 1'b1;
                    drain_results();
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_rate_report = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_ADJUST_DISABLE;
        i_cfg_data    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int ph = 0; ph < NUM_PHASES; ph++) run_phase(ph);

        drain_results();
        repeat (END_CYCLES) @(negedge i_clk);

        $display("Sent %0d throughput reports over %0d register settings, %0d long hold-off(s).",
                 reports_sent, NUM_PHASES + 6, long_holds);
        $display("Predicted %0d size halvings and %0d doublings in %0d cycles.",
                 halvings, doublings, cycle_count);
        if (mismatches == 0 && outstanding == 0) begin
            $display("link_packet_size_adapter_core regression: pass");
        end else begin
            $display("%0d mismatches, %0d results never delivered", mismatches, outstanding);
            $display("link_packet_size_adapter_core regression: fail");
        end
        $finish;
    end

endmodule
